### rtl/core/cfp_pkg.sv
package cfp_pkg;

  // byte and field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned TargetW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PayloadBytes = 4;
  localparam int unsigned PayloadIdxW = $clog2(PayloadBytes);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic signed [TargetW-1:0] target_t;

  // register reset values
  localparam byte_t HEADER_FIRST_RESET = 8'hAA;
  localparam byte_t HEADER_SECOND_RESET = 8'h55;
  localparam byte_t COMMAND_TYPE_RESET = 8'h10;

  // length byte that a velocity command must carry
  localparam byte_t FRAME_PAYLOAD_LEN = byte_t'(PayloadBytes);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_FIRST = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_COMMAND_TYPE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    byte_t header_first;
    byte_t header_second;
    byte_t command_type;
  } cfg_t;

  // one decoded command, valid for the item just consumed
  typedef struct packed {
    logic valid;
    target_t speed_target;
    target_t turn_rate_target;
  } result_t;

endpackage

### rtl/core/cfp_cfg_regs.sv
module cfp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  cfp_pkg::cfg_idx_t cfg_index,
  input  cfp_pkg::byte_t    cfg_data,
  output cfp_pkg::cfg_t     cfg
);
  import cfp_pkg::*;

  // register file, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first <= HEADER_FIRST_RESET;
      cfg.header_second <= HEADER_SECOND_RESET;
      cfg.command_type <= COMMAND_TYPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADER_FIRST: cfg.header_first <= cfg_data;
        REG_HEADER_SECOND: cfg.header_second <= cfg_data;
        REG_COMMAND_TYPE: cfg.command_type <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/cfp_in_reg.sv
module cfp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cfp_pkg::byte_t rx_byte,
  input  logic           take,
  output logic           held_valid,
  output cfp_pkg::byte_t held_byte
);
  import cfp_pkg::*;

  // register is free when empty or being consumed this cycle
  assign in_ready = !held_valid || take;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

### rtl/core/cfp_parse.sv
module cfp_parse (
  input  logic             clk,
  input  logic             rst,
  input  cfp_pkg::cfg_t    cfg,
  input  logic             take,
  input  cfp_pkg::byte_t   rx,
  output cfp_pkg::result_t res
);
  import cfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT_FIRST = 3'd0,
    PH_HUNT_SECOND = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  localparam logic [PayloadIdxW-1:0] LastIdx = PayloadIdxW'(PayloadBytes - 1);

  phase_t                 phase, phase_next;
  byte_t                  frame_kind, frame_kind_next;
  logic [PayloadIdxW-1:0] byte_index, byte_index_next;
  byte_t                  running_sum, running_sum_next;
  byte_t                  payload [PayloadBytes];
  byte_t                  sum_add;

  assign sum_add = running_sum + rx;

  // next state and result for the byte in the input register
  always_comb begin
    phase_next = phase;
    frame_kind_next = frame_kind;
    byte_index_next = byte_index;
    running_sum_next = running_sum;
    res.valid = 1'b0;
    res.speed_target = target_t'({payload[1], payload[0]});
    res.turn_rate_target = target_t'({payload[3], payload[2]});
    case (phase)
      PH_HUNT_FIRST: begin
        phase_next = (rx == cfg.header_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
      end
      PH_HUNT_SECOND: begin
        phase_next = (rx == cfg.header_second) ? PH_TYPE : PH_HUNT_FIRST;
      end
      PH_TYPE: begin
        frame_kind_next = rx;
        running_sum_next = rx;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        running_sum_next = sum_add;
        byte_index_next = '0;
        phase_next = (frame_kind == cfg.command_type && rx == FRAME_PAYLOAD_LEN)
                     ? PH_PAYLOAD : PH_HUNT_FIRST;
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_add;
        byte_index_next = byte_index + 1'b1;
        if (byte_index == LastIdx) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res.valid = take && (rx == running_sum);
        phase_next = PH_HUNT_FIRST;
      end
      default: begin
        phase_next = PH_HUNT_FIRST;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT_FIRST;
      frame_kind <= '0;
      byte_index <= '0;
      running_sum <= '0;
    end else if (take) begin
      phase <= phase_next;
      frame_kind <= frame_kind_next;
      byte_index <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  // payload store, every entry written in the frame before it is read
  always_ff @(posedge clk) begin
    if (take && phase == PH_PAYLOAD) begin
      payload[byte_index] <= rx;
    end
  end

endmodule

### rtl/core/cfp_out_reg.sv
module cfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  cfp_pkg::result_t  res,
  output logic              out_valid,
  input  logic              out_ready,
  output cfp_pkg::target_t  speed_target,
  output cfp_pkg::target_t  turn_rate_target
);
  import cfp_pkg::*;

  // take only happens when this slot is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result data
  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      speed_target <= res.speed_target;
      turn_rate_target <= res.turn_rate_target;
    end
  end

endmodule

### rtl/core/command_frame_parser_top.sv
// Velocity command frame parser. One received byte per item on the rx_byte
// channel; the block hunts for the two header bytes, checks the type and a
// length of 4, gathers four payload bytes and compares the checksum byte with
// the 8-bit sum of type, length and payload. A good frame gives one item of
// signed little-endian speed_target and turn_rate_target; a bad frame gives
// nothing and the parser goes back to hunting for the first header. Each byte
// is held in an input register and parsed by the state logic, and any result
// lands in the output register, so a byte can be taken every cycle while the
// output side keeps up. The checksum byte passes through the input register
// and then the output register before its result shows. The user must write
// registers 0 to 2 (first header, second header, command type) through
// cfg_write only while the channel is idle; the block does not enforce this.
module command_frame_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  cfp_pkg::cfg_idx_t cfg_index,
  input  cfp_pkg::byte_t    cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfp_pkg::byte_t    rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output cfp_pkg::target_t  speed_target,
  output cfp_pkg::target_t  turn_rate_target
);
  import cfp_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    held_valid;
  byte_t   held_byte;
  logic    take;

  // consume the held byte whenever the result slot can take its outcome
  assign take = held_valid && (!out_valid || out_ready);

  cfp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cfp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .rx   (held_byte),
    .res  (res)
  );

  cfp_out_reg u_out_reg (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .res              (res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .speed_target     (speed_target),
    .turn_rate_target (turn_rate_target)
  );

endmodule

### rtl/core/cfp_checker.sv
module cfp_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input cfp_pkg::target_t speed_target,
  input cfp_pkg::target_t turn_rate_target
);
  import cfp_pkg::*;

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or input blocked after reset");

  // a new result follows an earlier byte taken on the input channel
  a_result_after_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a byte two cycles earlier");

  // a stalled result keeps its data
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(speed_target) && $stable(turn_rate_target))
    else $error("stalled result changed");

endmodule

bind command_frame_parser_top cfp_checker u_cfp_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .speed_target     (speed_target),
  .turn_rate_target (turn_rate_target)
);

### tb/command_frame_checker.sv
module command_frame_checker
  import cfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data,
  input  logic     in_valid,
  input  logic     in_ready,
  input  byte_t    rx_byte,
  input  logic     out_valid,
  input  logic     out_ready,
  input  target_t  speed_target,
  input  target_t  turn_rate_target,
  output int       error_count,
  output int       pending_count
);

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_TYPE,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } parse_phase_t;

  typedef struct packed {
    target_t speed;
    target_t turn;
  } velocity_cmd_t;

  cfg_t          regs;
  parse_phase_t  phase;
  byte_t         kind;
  byte_t         sum;
  logic [2:0]    payload_count;
  byte_t         payload [PayloadBytes];
  velocity_cmd_t pending_commands [$];
  velocity_cmd_t want;
  int            errors;

  // walk the frame parser one byte forward, queueing a command on a good checksum
  task automatic parse_byte(input byte_t b);
    case (phase)
      HUNT_FIRST: begin
        phase = (b == regs.header_first) ? HUNT_SECOND : HUNT_FIRST;
      end
      HUNT_SECOND: begin
        phase = (b == regs.header_second) ? TAKE_TYPE : HUNT_FIRST;
      end
      TAKE_TYPE: begin
        kind = b;
        sum = b;
        phase = TAKE_LENGTH;
      end
      TAKE_LENGTH: begin
        sum = sum + b;
        payload_count = '0;
        phase = (kind == regs.command_type && b == FRAME_PAYLOAD_LEN) ? TAKE_PAYLOAD
                                                                      : HUNT_FIRST;
      end
      TAKE_PAYLOAD: begin
        payload[payload_count[PayloadIdxW-1:0]] = b;
        sum = sum + b;
        payload_count = payload_count + 3'd1;
        if (payload_count >= PayloadBytes) phase = TAKE_CHECKSUM;
      end
      TAKE_CHECKSUM: begin
        if (b == sum) begin
          pending_commands.push_back(velocity_cmd_t'{
            speed: target_t'({payload[1], payload[0]}),
            turn:  target_t'({payload[3], payload[2]})});
        end
        phase = HUNT_FIRST;
      end
      default: begin
        phase = HUNT_FIRST;
      end
    endcase
  endtask

  // follow register writes, predict from accepted bytes, check each result item
  always @(posedge clk) begin
    if (rst) begin
      regs = '{HEADER_FIRST_RESET, HEADER_SECOND_RESET, COMMAND_TYPE_RESET};
      phase = HUNT_FIRST;
      kind = '0;
      sum = '0;
      payload_count = '0;
      foreach (payload[i]) payload[i] = '0;
      pending_commands.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEADER_FIRST:  regs.header_first = cfg_data;
          REG_HEADER_SECOND: regs.header_second = cfg_data;
          REG_COMMAND_TYPE:  regs.command_type = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (pending_commands.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with none expected: speed_target %0d turn_rate_target %0d",
                     $time, speed_target, turn_rate_target);
          errors++;
        end else begin
          want = pending_commands.pop_front();
          if (speed_target !== want.speed || turn_rate_target !== want.turn) begin
            if (errors < 10)
              $display("%0t: speed_target exp %0d got %0d, turn_rate_target exp %0d got %0d",
                       $time, want.speed, speed_target, want.turn, turn_rate_target);
            errors++;
          end
        end
      end
    end
    error_count <= errors;
    pending_count <= pending_commands.size();
  end

endmodule

### tb/command_frame_parser_top_test.sv
module command_frame_parser_top_test;
  import cfp_pkg::*;

  localparam int StallLimit = 200;
  localparam int SettleCycles = 4;
  localparam int FinalCycles = 8;
  localparam int BytesPerSetting = 200;
  localparam int Settings = 8;
  // no register answers at this index
  localparam cfg_idx_t SpareIndex = '1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_write = 1'b0;
  cfg_idx_t cfg_index = REG_HEADER_FIRST;
  byte_t    cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  byte_t    rx_byte = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  target_t  speed_target;
  target_t  turn_rate_target;
  int       error_count;
  int       pending_count;

  cfg_t regs = '{HEADER_FIRST_RESET, HEADER_SECOND_RESET, COMMAND_TYPE_RESET};
  int   tx_gap_max = 11;
  int   rx_stall_max = 11;
  int   ready_wait = 0;
  int   idle_cycles = 0;
  int   sent = 0;

  always #2 clk = ~clk;

  command_frame_parser_top DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .speed_target     (speed_target),
    .turn_rate_target (turn_rate_target)
  );

  command_frame_checker frame_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .speed_target     (speed_target),
    .turn_rate_target (turn_rate_target),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  // output side holds off a random number of cycles after each item
  always @(posedge clk) begin : rx_side
    int stall;
    if (rst) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
    end else if (!out_ready) begin
      if (ready_wait == 0) out_ready <= 1'b1;
      else ready_wait <= ready_wait - 1;
    end else if (out_valid) begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        ready_wait <= stall - 1;
      end
    end
  end

  // watchdog: give up when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no item moved for %0d cycles", StallLimit);
      $display("command_frame_parser_top_test NOT OK");
      $finish;
    end
  end

  // mostly random bytes, with the extremes drawn more often
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one byte after a random gap and wait for it to be taken
  task automatic send_byte(input byte_t b);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // full frame with the current headers, checksum optionally spoilt
  task automatic send_frame(input byte_t kind, input byte_t len, input logic [31:0] body,
                            input logic bad_sum);
    byte_t sum;
    sum = kind + len;
    for (int i = 0; i < PayloadBytes; i++) sum = sum + body[8*i +: 8];
    if (bad_sum) sum = sum ^ byte_t'($urandom_range(1, 255));
    send_byte(regs.header_first);
    send_byte(regs.header_second);
    send_byte(kind);
    send_byte(len);
    for (int i = 0; i < PayloadBytes; i++) send_byte(body[8*i +: 8]);
    send_byte(sum);
  endtask

  // wait for every expected result, then for anything still in flight
  task automatic settle(input int tail);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // write all three registers, plus the unused index which must change nothing
  task automatic load_registers(input cfg_t setting);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEADER_FIRST;
    cfg_data <= setting.header_first;
    @(posedge clk);
    cfg_index <= REG_HEADER_SECOND;
    cfg_data <= setting.header_second;
    @(posedge clk);
    cfg_index <= REG_COMMAND_TYPE;
    cfg_data <= setting.command_type;
    @(posedge clk);
    cfg_index <= SpareIndex;
    cfg_data <= pick_byte();
    @(posedge clk);
    cfg_write <= 1'b0;
    regs = setting;
  endtask

  initial begin
    cfg_t        setting;
    int          choice;
    int          stop_at;
    logic [31:0] body;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: payload extremes, bad checksum, header retry, wrong type and length
    send_frame(COMMAND_TYPE_RESET, FRAME_PAYLOAD_LEN, 32'h7FFF_8000, 1'b0);
    send_frame(COMMAND_TYPE_RESET, FRAME_PAYLOAD_LEN, 32'h0102_FFFF, 1'b1);
    // a repeated first header is not taken as a fresh start
    send_byte(HEADER_FIRST_RESET);
    send_byte(HEADER_FIRST_RESET);
    send_byte(HEADER_SECOND_RESET);
    send_byte(HEADER_FIRST_RESET);
    send_byte(HEADER_SECOND_RESET);
    send_byte(COMMAND_TYPE_RESET + 8'd1);
    send_byte(FRAME_PAYLOAD_LEN);
    send_byte(HEADER_FIRST_RESET);
    send_byte(HEADER_SECOND_RESET);
    send_byte(COMMAND_TYPE_RESET);
    send_byte(FRAME_PAYLOAD_LEN + 8'd1);

    // random traffic under a run of register settings
    for (int s = 0; s < Settings; s++) begin
      in_valid <= 1'b0;
      settle(SettleCycles);
      case (s)
        0: setting = '{8'h00, 8'h00, 8'h00};
        1: setting = '{8'hFF, 8'hFF, 8'hFF};
        2: setting = '{HEADER_FIRST_RESET, HEADER_SECOND_RESET, COMMAND_TYPE_RESET};
        default: setting = '{pick_byte(), pick_byte(), pick_byte()};
      endcase
      load_registers(setting);

      // pick how hard each side idles; one stretch runs flat out
      case ($urandom_range(0, 2))
        0: tx_gap_max = 0;
        1: tx_gap_max = 3;
        default: tx_gap_max = 11;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_max = 0;
        1: rx_stall_max = 3;
        default: rx_stall_max = 11;
      endcase
      if (s == 3) begin
        tx_gap_max = 0;
        rx_stall_max = 0;
      end

      stop_at = sent + BytesPerSetting;
      while (sent < stop_at) begin
        choice = $urandom_range(0, 99);
        body = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        if (choice < 65) begin
          send_frame(regs.command_type, FRAME_PAYLOAD_LEN, body, 1'b0);
        end else if (choice < 72) begin
          send_frame(regs.command_type, FRAME_PAYLOAD_LEN, body, 1'b1);
        end else if (choice < 77) begin
          send_frame(regs.command_type ^ byte_t'($urandom_range(1, 255)),
                     FRAME_PAYLOAD_LEN, body, 1'b0);
        end else if (choice < 82) begin
          send_frame(regs.command_type,
                     FRAME_PAYLOAD_LEN ^ byte_t'($urandom_range(1, 255)), body, 1'b0);
        end else if (choice < 88) begin
          // first header followed by a random second byte
          send_byte(regs.header_first);
          send_byte(pick_byte());
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        end
      end
    end

    in_valid <= 1'b0;
    settle(FinalCycles);
    if (error_count == 0 && pending_count == 0) begin
      $display("command_frame_parser_top_test OK");
    end else begin
      $display("command_frame_parser_top_test NOT OK");
    end
    $finish;
  end

endmodule
